FILE: hw/rtl/tcw_pkg.sv
// Package with the screen geometry, character codes and shared types of the console writer.
package tcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;

    localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int MOVE_COUNT = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int ROW_W  = (SCREEN_ROWS > 2) ? $clog2(SCREEN_ROWS) : 1;
    localparam int COL_W  = (SCREEN_COLUMNS > 2) ? $clog2(SCREEN_COLUMNS) : 1;

    localparam int ROW_FIELD_W  = 5;
    localparam int COL_FIELD_W  = 7;
    localparam int CHAR_W       = 8;
    localparam int CELL_W       = 16;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] ATTR_RESET     = 8'd15;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic             wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scroll;
    } cursor_upd_t;

endpackage

FILE: hw/rtl/tcw_screen_ram.sv
// Screen cell memory with one write port and one registered read port.
module tcw_screen_ram (
    input  logic                        clk,
    input  tcw_pkg::ram_wr_t            wr,
    input  logic [tcw_pkg::ADDR_W-1:0]  rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/tcw_cursor.sv
// Cursor update and cell write for one put-character command.
module tcw_cursor (
    input  logic [tcw_pkg::ROW_W-1:0]  row,
    input  logic [tcw_pkg::COL_W-1:0]  col,
    input  logic [tcw_pkg::CHAR_W-1:0] char_code,
    input  logic [tcw_pkg::CHAR_W-1:0] attr,
    output tcw_pkg::cursor_upd_t       upd
);

    logic [tcw_pkg::ROW_W:0]   row_w;
    logic [tcw_pkg::COL_W-1:0] col_n;
    logic [tcw_pkg::ROW_W-1:0] row_pos;
    logic [tcw_pkg::COL_W-1:0] col_pos;
    logic                      act;
    logic                      we;
    logic [tcw_pkg::CELL_W-1:0] data;
    logic                      scroll;

    always_comb
    begin
        row_w   = {1'b0, row};
        col_n   = col;
        row_pos = row;
        col_pos = col;
        act     = 1'b1;
        we      = 1'b0;
        data    = '0;
        if (char_code == tcw_pkg::CHAR_NEWLINE)
        begin
            col_n = '0;
            row_w = {1'b0, row} + 1'b1;
        end
        else if (char_code == tcw_pkg::CHAR_BACKSPACE)
        begin
            if (row == '0 && col == '0)
            begin
                act = 1'b0;
            end
            else
            begin
                if (col == '0)
                begin
                    row_w = {1'b0, row} - 1'b1;
                    col_n = tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1);
                end
                else
                begin
                    col_n = col - 1'b1;
                end
                we      = 1'b1;
                row_pos = row_w[tcw_pkg::ROW_W-1:0];
                col_pos = col_n;
            end
        end
        else
        begin
            we   = 1'b1;
            data = {attr, char_code};
            if (col == tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1))
            begin
                col_n = '0;
                row_w = {1'b0, row} + 1'b1;
            end
            else
            begin
                col_n = col + 1'b1;
            end
        end
        scroll = act && (row_w == (tcw_pkg::ROW_W + 1)'(tcw_pkg::SCREEN_ROWS));
    end

    always_comb
    begin
        upd.wr_en   = we;
        upd.wr_addr = tcw_pkg::ADDR_W'(int'(row_pos) * tcw_pkg::SCREEN_COLUMNS + int'(col_pos));
        upd.wr_data = data;
        upd.row     = scroll ? tcw_pkg::ROW_W'(row_w - 1'b1) : row_w[tcw_pkg::ROW_W-1:0];
        upd.col     = col_n;
        upd.scroll  = scroll;
    end

endmodule

FILE: hw/rtl/text_console_character_writer_top.sv
// Top level of the text console character writer: sequencer, cursor and screen memory.
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  input    | in_valid, in_ready, command, char_code,          | in
//           | last_in_call, read_row, read_column              |
//  output   | out_valid, out_ready, cell_char, cell_attr,      | out
//           | cursor_row_out, cursor_column_out, scrolled      |
//  config   | attr_wr_en, attr_wr_data                         | in
//
// After reset the screen memory is cleared one cell per cycle, all 2000 cells, before in_ready
// rises.
// A put that does not scroll does the cursor update and cell write as it is accepted and then
// loads the output register in S_HOLD; a read passes through S_READ first because the memory read port is registered.
// A scroll moves 1920 cells and clears 80 through the single address counter.
// While a result waits on a stalled output, one more transfer is accepted and processed.
module text_console_character_writer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] char_code,
    input  logic       last_in_call,
    input  logic [4:0] read_row,
    input  logic [6:0] read_column,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cell_char,
    output logic [7:0] cell_attr,
    output logic [4:0] cursor_row_out,
    output logic [6:0] cursor_column_out,
    output logic       scrolled,
    input  logic       attr_wr_en,
    input  logic [7:0] attr_wr_data
);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_HOLD   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [tcw_pkg::ADDR_W-1:0] cnt_reg, cnt_next;
    logic                       mv_pend_reg, mv_pend_next;
    logic [tcw_pkg::ADDR_W-1:0] mv_dst_reg, mv_dst_next;
    logic [tcw_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [tcw_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [7:0]                 attr_reg;
    logic                       rd_ok_reg, rd_ok_next;

    logic [7:0] res_char_reg, res_char_next;
    logic [7:0] res_attr_reg, res_attr_next;
    logic       res_scroll_reg, res_scroll_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_attr_reg;
    logic [4:0] out_row_reg;
    logic [6:0] out_col_reg;
    logic       out_scroll_reg;
    logic       out_load;

    logic                       accept;
    logic                       rd_in_range;
    logic [tcw_pkg::ADDR_W-1:0] rd_in_addr;
    logic [tcw_pkg::ADDR_W-1:0] cnt_inc;
    logic [tcw_pkg::ADDR_W-1:0] rd_addr;
    logic [tcw_pkg::CELL_W-1:0] rd_data;
    tcw_pkg::ram_wr_t           wr;
    tcw_pkg::cursor_upd_t       upd;

    tcw_cursor u_cursor (
        .row       (cur_row_reg),
        .col       (cur_col_reg),
        .char_code (char_code),
        .attr      (attr_reg),
        .upd       (upd)
    );

    tcw_screen_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign rd_in_range = (int'(read_row) < tcw_pkg::SCREEN_ROWS)
                         && (int'(read_column) < tcw_pkg::SCREEN_COLUMNS);
    assign rd_in_addr  = tcw_pkg::ADDR_W'(int'(read_row) * tcw_pkg::SCREEN_COLUMNS
                         + int'(read_column));
    assign cnt_inc     = cnt_reg + 1'b1;
    assign out_load    = (state_reg == S_HOLD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        rd_addr = rd_in_addr;
        if (state_reg == S_SCROLL)
        begin
            rd_addr = tcw_pkg::ADDR_W'(cnt_reg + tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLUMNS));
        end
    end

    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = cnt_reg;
        wr.data = '0;
        if (mv_pend_reg)
        begin
            wr.en   = 1'b1;
            wr.addr = mv_dst_reg;
            wr.data = rd_data;
        end
        else if (state_reg == S_INIT || state_reg == S_CLEAR)
        begin
            wr.en = 1'b1;
        end
        else if (accept && command == tcw_pkg::CMD_PUT)
        begin
            wr.en   = upd.wr_en;
            wr.addr = upd.wr_addr;
            wr.data = upd.wr_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        mv_pend_next    = 1'b0;
        mv_dst_next     = mv_dst_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        rd_ok_next      = rd_ok_reg;
        res_char_next   = res_char_reg;
        res_attr_next   = res_attr_reg;
        res_scroll_next = res_scroll_reg;
        case (state_reg)
            S_INIT:
            begin
                cnt_next = cnt_inc;
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == tcw_pkg::CMD_READ)
                    begin
                        rd_ok_next = rd_in_range;
                        state_next = S_READ;
                    end
                    else
                    begin
                        cur_row_next    = upd.row;
                        cur_col_next    = upd.col;
                        res_char_next   = '0;
                        res_attr_next   = '0;
                        res_scroll_next = upd.scroll;
                        cnt_next        = '0;
                        state_next      = upd.scroll ? S_SCROLL : S_HOLD;
                    end
                end
            end
            S_READ:
            begin
                res_char_next   = rd_ok_reg ? rd_data[7:0] : 8'd0;
                res_attr_next   = rd_ok_reg ? rd_data[15:8] : 8'd0;
                res_scroll_next = 1'b0;
                state_next      = S_HOLD;
            end
            S_SCROLL:
            begin
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::MOVE_COUNT))
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    mv_pend_next = 1'b1;
                    mv_dst_next  = cnt_reg;
                    cnt_next     = cnt_inc;
                end
            end
            S_CLEAR:
            begin
                cnt_next = cnt_inc;
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            mv_pend_reg   <= 1'b0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mv_pend_reg   <= mv_pend_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            out_valid_reg <= out_valid_next;
            if (attr_wr_en)
            begin
                attr_reg <= attr_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mv_dst_reg     <= mv_dst_next;
        rd_ok_reg      <= rd_ok_next;
        res_char_reg   <= res_char_next;
        res_attr_reg   <= res_attr_next;
        res_scroll_reg <= res_scroll_next;
        if (out_load)
        begin
            out_char_reg   <= res_char_reg;
            out_attr_reg   <= res_attr_reg;
            out_row_reg    <= tcw_pkg::ROW_FIELD_W'(cur_row_reg);
            out_col_reg    <= tcw_pkg::COL_FIELD_W'(cur_col_reg);
            out_scroll_reg <= res_scroll_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign cell_char         = out_char_reg;
    assign cell_attr         = out_attr_reg;
    assign cursor_row_out    = out_row_reg;
    assign cursor_column_out = out_col_reg;
    assign scrolled          = out_scroll_reg;

endmodule

FILE: bench/tb_top.sv
// Testbench for the text console character writer: directed table, random phases, checking.
`timescale 1ns / 1ps

module tb_top;

    localparam int SENDER_PHASES = 5;
    localparam int PHASE_ITEMS   = 126;
    localparam int HOLD_AFTER    = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic       cmd;
        logic [7:0] code;
        logic       last;
        logic [4:0] rrow;
        logic [6:0] rcol;
    } console_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] crow;
        logic [6:0] ccol;
        logic       scrolled;
    } console_result_t;

    typedef struct packed {
        logic            typed;
        console_item_t   item;
        console_result_t res;
    } directed_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       command;
    logic [7:0] char_code;
    logic       last_in_call;
    logic [4:0] read_row;
    logic [6:0] read_column;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_column_out;
    logic       scrolled;
    logic       attr_wr_en;
    logic [7:0] attr_wr_data;

    logic [15:0]     screen_model [tcw_pkg::CELL_COUNT];
    logic [4:0]      cursor_row_model;
    logic [6:0]      cursor_col_model;
    logic [7:0]      attr_model;
    console_result_t expected_cells [$];
    directed_row_t   directed_rows [$];

    int error_count  = 0;
    int items_sent   = 0;
    int reads_sent   = 0;
    int scroll_count = 0;
    int results_seen = 0;

    text_console_character_writer_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .char_code         (char_code),
        .last_in_call      (last_in_call),
        .read_row          (read_row),
        .read_column       (read_column),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .cell_char         (cell_char),
        .cell_attr         (cell_attr),
        .cursor_row_out    (cursor_row_out),
        .cursor_column_out (cursor_column_out),
        .scrolled          (scrolled),
        .attr_wr_en        (attr_wr_en),
        .attr_wr_data      (attr_wr_data)
    );

    always #5 clk = ~clk;

    function automatic console_result_t predict_console(input console_item_t it);
        console_result_t r;
        int row;
        int col;
        int i;
        int addr;
        bit act;
        r = '0;
        if (it.cmd == tcw_pkg::CMD_READ)
        begin
            if (int'(it.rrow) < tcw_pkg::SCREEN_ROWS && int'(it.rcol) < tcw_pkg::SCREEN_COLUMNS)
            begin
                addr = int'(it.rrow) * tcw_pkg::SCREEN_COLUMNS + int'(it.rcol);
                r.cell_char = screen_model[addr][7:0];
                r.cell_attr = screen_model[addr][15:8];
            end
        end
        else
        begin
            row = int'(cursor_row_model);
            col = int'(cursor_col_model);
            act = 1'b1;
            if (it.code == tcw_pkg::CHAR_NEWLINE)
            begin
                col = 0;
                row++;
            end
            else if (it.code == tcw_pkg::CHAR_BACKSPACE)
            begin
                if (row == 0 && col == 0)
                begin
                    act = 1'b0;
                end
                else
                begin
                    if (col == 0)
                    begin
                        row--;
                        col = tcw_pkg::SCREEN_COLUMNS;
                    end
                    col--;
                    screen_model[row * tcw_pkg::SCREEN_COLUMNS + col] = '0;
                end
            end
            else
            begin
                screen_model[row * tcw_pkg::SCREEN_COLUMNS + col] = {attr_model, it.code};
                col++;
                if (col >= tcw_pkg::SCREEN_COLUMNS)
                begin
                    col = 0;
                    row++;
                end
            end
            if (act && row >= tcw_pkg::SCREEN_ROWS)
            begin
                for (i = 0; i < tcw_pkg::MOVE_COUNT; i++)
                    screen_model[i] = screen_model[i + tcw_pkg::SCREEN_COLUMNS];
                for (i = tcw_pkg::MOVE_COUNT; i < tcw_pkg::CELL_COUNT; i++)
                    screen_model[i] = '0;
                row--;
                r.scrolled = 1'b1;
            end
            cursor_row_model = 5'(row);
            cursor_col_model = 7'(col);
        end
        r.crow = cursor_row_model;
        r.ccol = cursor_col_model;
        return r;
    endfunction

    function automatic console_item_t random_item();
        console_item_t it;
        int unsigned pick;
        it.cmd  = ($urandom_range(0, 3) == 0) ? tcw_pkg::CMD_READ : tcw_pkg::CMD_PUT;
        it.code = 8'($urandom_range(0, 255));
        it.last = 1'($urandom_range(0, 1));
        it.rrow = 5'($urandom_range(0, 31));
        it.rcol = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (it.cmd == tcw_pkg::CMD_PUT)
        begin
            if (pick < 12)
                it.code = tcw_pkg::CHAR_NEWLINE;
            else if (pick < 20)
                it.code = tcw_pkg::CHAR_BACKSPACE;
        end
        else if (pick < 45)
        begin
            it.rrow = cursor_row_model;
            it.rcol = 7'($urandom_range(0, tcw_pkg::SCREEN_COLUMNS - 1));
        end
        else if (pick < 90)
        begin
            it.rrow = 5'($urandom_range(0, tcw_pkg::SCREEN_ROWS - 1));
            it.rcol = 7'($urandom_range(0, tcw_pkg::SCREEN_COLUMNS - 1));
        end
        return it;
    endfunction

    task automatic add_row(input logic typed, input logic cmd, input logic [7:0] code,
                           input logic last, input logic [4:0] rrow, input logic [6:0] rcol,
                           input logic [7:0] xchar, input logic [7:0] xattr,
                           input logic [4:0] xrow, input logic [6:0] xcol, input logic xscr);
        directed_row_t d;
        d.typed         = typed;
        d.item.cmd      = cmd;
        d.item.code     = code;
        d.item.last     = last;
        d.item.rrow     = rrow;
        d.item.rcol     = rcol;
        d.res.cell_char = xchar;
        d.res.cell_attr = xattr;
        d.res.crow      = xrow;
        d.res.ccol      = xcol;
        d.res.scrolled  = xscr;
        directed_rows.push_back(d);
    endtask

    task automatic offer_item(input console_item_t it, input logic typed,
                              input console_result_t typed_res, input int gap);
        console_result_t r;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= it.cmd;
        char_code    <= it.code;
        last_in_call <= it.last;
        read_row     <= it.rrow;
        read_column  <= it.rcol;
        do @(posedge clk); while (in_ready !== 1'b1);
        r = predict_console(it);
        expected_cells.push_back(typed ? typed_res : r);
        items_sent++;
        if (it.cmd == tcw_pkg::CMD_READ)
            reads_sent++;
    endtask

    task automatic wait_for_results();
        while (expected_cells.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        wait_for_results();
        attr_wr_en   <= 1'b1;
        attr_wr_data <= value;
        @(posedge clk);
        attr_wr_en   <= 1'b0;
        attr_model = value;
    endtask

    function automatic int sender_gap(input int idx);
        if ((idx / 50) % 4 == 2)
            return 0;
        return int'($urandom_range(0, 6));
    endfunction

    initial
    begin : stimulus
        console_item_t it;
        int idx;
        int p;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= tcw_pkg::CMD_PUT;
        char_code    <= '0;
        last_in_call <= 1'b0;
        read_row     <= '0;
        read_column  <= '0;
        attr_wr_en   <= 1'b0;
        attr_wr_data <= '0;
        foreach (screen_model[i])
            screen_model[i] = '0;
        cursor_row_model = '0;
        cursor_col_model = '0;
        attr_model = tcw_pkg::ATTR_RESET;

        add_row(1'b1, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd0, 7'd0,
                8'h00, 8'h00, 5'd0, 7'd0, 1'b0);
        add_row(1'b1, tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE, 1'b1, 5'd0, 7'd0,
                8'h00, 8'h00, 5'd0, 7'd0, 1'b0);
        add_row(1'b1, tcw_pkg::CMD_PUT, 8'h41, 1'b0, 5'd0, 7'd0,
                8'h00, 8'h00, 5'd0, 7'd1, 1'b0);
        add_row(1'b1, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd0, 7'd0,
                8'h41, tcw_pkg::ATTR_RESET, 5'd0, 7'd1, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, 8'h00, 1'b0, 5'd31, 7'd127, '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, 8'hFF, 1'b1, 5'd0, 7'd0, '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd0, 7'd1, '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_READ, 8'hFF, 1'b1, 5'd0, 7'd2, '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE, 1'b0, 5'd0, 7'd0,
                '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd0, 7'd2, '0, '0, '0, '0, 1'b0);
        add_row(1'b1, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd31, 7'd0,
                8'h00, 8'h00, 5'd0, 7'd2, 1'b0);
        add_row(1'b1, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd0, 7'd127,
                8'h00, 8'h00, 5'd0, 7'd2, 1'b0);
        add_row(1'b1, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd25, 7'd80,
                8'h00, 8'h00, 5'd0, 7'd2, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd24, 7'd79, '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, 1'b1, 5'd0, 7'd0,
                '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE, 1'b0, 5'd0, 7'd0,
                '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, 8'h7E, 1'b0, 5'd0, 7'd0, '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd0, 7'd79, '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, 8'h80, 1'b1, 5'd0, 7'd0, '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE, 1'b0, 5'd0, 7'd0,
                '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE, 1'b0, 5'd0, 7'd0,
                '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd0, 7'd79, '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, 1'b0, 5'd0, 7'd0,
                '0, '0, '0, '0, 1'b0);
        add_row(1'b0, tcw_pkg::CMD_READ, 8'h00, 1'b0, 5'd1, 7'd0, '0, '0, '0, '0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx = 0;
        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res,
                       sender_gap(idx));
            idx++;
        end
        in_valid <= 1'b0;

        for (p = 0; p < SENDER_PHASES; p++)
        begin
            if (p == 0)
                write_attribute(8'h00);
            else if (p == 1)
                write_attribute(8'hFF);
            else
                write_attribute(8'($urandom_range(0, 255)));
            repeat (PHASE_ITEMS)
            begin
                it = random_item();
                offer_item(it, 1'b0, '0, sender_gap(idx));
                idx++;
            end
            in_valid <= 1'b0;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d transfers (%0d reads) and checked %0d results, %0d of them scrolls.",
                 items_sent, reads_sent, results_seen, scroll_count);
        $display("Attributes covered the reset value, 0x00, 0xFF and three random values.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : result_checker
        console_result_t want;
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen == HOLD_AFTER)
                gap = HOLD_CYCLES;
            else if ((results_seen / 40) % 3 == 1)
                gap = 0;
            else
                gap = int'($urandom_range(0, 6));
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            results_seen++;
            if (scrolled === 1'b1)
                scroll_count++;
            if (expected_cells.size() == 0)
            begin
                $error("Result transfer arrived with no expectation pending.");
                error_count++;
            end
            else
            begin
                want = expected_cells.pop_front();
                if (cell_char !== want.cell_char)
                begin
                    $error("cell_char expected %0h actual %0h", want.cell_char, cell_char);
                    error_count++;
                end
                if (cell_attr !== want.cell_attr)
                begin
                    $error("cell_attr expected %0h actual %0h", want.cell_attr, cell_attr);
                    error_count++;
                end
                if (cursor_row_out !== want.crow)
                begin
                    $error("cursor_row_out expected %0d actual %0d", want.crow, cursor_row_out);
                    error_count++;
                end
                if (cursor_column_out !== want.ccol)
                begin
                    $error("cursor_column_out expected %0d actual %0d",
                           want.ccol, cursor_column_out);
                    error_count++;
                end
                if (scrolled !== want.scrolled)
                begin
                    $error("scrolled expected %0d actual %0d", want.scrolled, scrolled);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #60_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
